@@ design/lscps_pkg.sv @@
`default_nettype none

package lscps_pkg;

    // Q8 length fraction, relative to the integer coordinate grid
    localparam int QF = 8;

    // square-root units: 60-bit radicand, 30-bit root, one root bit per stage
    localparam int SQ_IN_W   = 60;
    localparam int SQ_OUT_W  = SQ_IN_W / 2;
    localparam int SQ_STAGES = SQ_OUT_W;

    // divider: 57-bit numerator, 29-bit divisor and quotient, one quotient bit per stage
    localparam int DIV_NUM_W  = 57;
    localparam int DIV_DEN_W  = 29;
    localparam int DIV_Q_W    = 29;
    localparam int DIV_STAGES = DIV_Q_W;

    // input regs, sqrt, numerator, divider, square, discriminant, sqrt, roots, path, output
    localparam int PIPE_DEPTH = 3 + SQ_STAGES + 1 + DIV_STAGES + 1 + 1 + SQ_STAGES + 3;

    localparam logic signed [18:0] CZ_RESET     = 19'sd1728;
    localparam logic        [17:0] RADIUS_RESET = 18'd96967;

    typedef enum logic [0:0] {
        CFG_CENTER_Z = 1'b0,
        CFG_RADIUS   = 1'b1
    } t_cfg_idx;

    // side data riding alongside the first square root
    typedef struct packed {
        logic        dot_neg;
        logic [39:0] dot_mag;
        logic [39:0] w2;
        logic        zero;
    } t_sq1_side;

    // side data riding alongside the divider
    typedef struct packed {
        logic        dot_neg;
        logic [39:0] w2;
        logic [28:0] drq;
        logic        zero;
    } t_div_side;

    // side data riding alongside the second square root
    typedef struct packed {
        logic signed [29:0] u;
        logic        [28:0] drq;
        logic               vtx_in;
        logic               spos;
        logic               zero;
    } t_sq2_side;

endpackage

`default_nettype wire

@@ design/lscps_sqrt.sv @@
`default_nettype none

// Pipelined integer square root, floor(sqrt(n)), one root bit per stage.
module lscps_sqrt import lscps_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire logic [SQ_IN_W-1:0]  i_radicand,
    output logic      [SQ_OUT_W-1:0] o_root
);

    logic [SQ_IN_W-1:0]  r_rem  [SQ_STAGES-1];
    logic [SQ_OUT_W-1:0] r_root [SQ_STAGES];

    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
        localparam int B = SQ_STAGES - 1 - k;
        logic [SQ_IN_W-1:0]  rem_in;
        logic [SQ_OUT_W-1:0] root_in;
        logic [SQ_IN_W:0]    trial;
        logic                fits;

        if (k == 0) begin : g_first
            assign rem_in  = i_radicand;
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
        end

        // (root + 2^B)^2 - root^2 = root * 2^(B+1) + 2^(2B)
        assign trial = ((SQ_IN_W+1)'(root_in) << (B + 1)) | ((SQ_IN_W+1)'(1) << (2 * B));
        assign fits  = {1'b0, rem_in} >= trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[k] <= fits ? (root_in | (SQ_OUT_W'(1) << B)) : root_in;
            end
        end

        if (k < SQ_STAGES - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= fits ? (rem_in - trial[SQ_IN_W-1:0]) : rem_in;
                end
            end
        end
    end

    assign o_root = r_root[SQ_STAGES-1];

endmodule

`default_nettype wire

@@ design/lscps_div.sv @@
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage.
// Quotient must fit DIV_Q_W bits.
module lscps_div import lscps_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire logic [DIV_NUM_W-1:0] i_num,
    input  wire logic [DIV_DEN_W-1:0] i_den,
    output logic      [DIV_Q_W-1:0]   o_quo
);

    logic [DIV_NUM_W-1:0] r_rem [DIV_STAGES-1];
    logic [DIV_DEN_W-1:0] r_den [DIV_STAGES-1];
    logic [DIV_Q_W-1:0]   r_quo [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        localparam int B = DIV_STAGES - 1 - k;
        logic [DIV_NUM_W-1:0] rem_in;
        logic [DIV_DEN_W-1:0] den_in;
        logic [DIV_Q_W-1:0]   quo_in;
        logic [DIV_NUM_W-1:0] trial;
        logic                 fits;

        if (k == 0) begin : g_first
            assign rem_in = i_num;
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign den_in = r_den[k-1];
            assign quo_in = r_quo[k-1];
        end

        assign trial = DIV_NUM_W'(den_in) << B;
        assign fits  = rem_in >= trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[k] <= fits ? (quo_in | (DIV_Q_W'(1) << B)) : quo_in;
            end
        end

        if (k < DIV_STAGES - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= fits ? (rem_in - trial) : rem_in;
                    r_den[k] <= den_in;
                end
            end
        end
    end

    assign o_quo = r_quo[DIV_STAGES-1];

endmodule

`default_nettype wire

@@ design/line_sphere_chord_path_split.sv @@
`default_nettype none

// Channel | Direction | Handshake               | Word
// --------+-----------+-------------------------+----------------------------------------
// in      | in        | i_in_valid / o_in_ready | vertex x/y/z, sensor x/y/z (19b signed)
// out     | out       | o_out_valid/i_out_ready | length_inside 19b, length_outside 21b s
// cfg     | in        | i_cfg_valid/o_cfg_ready | index 1b, data 19b (centre z, radius)
//
// One word per cycle sustained while the output keeps up; pipe depth is set by the two
// 30-stage square roots and the 29-stage divider in line.
// Whole pipe moves on one enable: it advances when the output register is empty
// or being taken, so a stall freezes every stage and nothing is lost or repeated.
// Synchronous active-low reset clears valids and loads the register reset values.
// Config port is always ready; writes are expected only while the pipe is empty.
module line_sphere_chord_path_split import lscps_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,

    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic signed [18:0] i_vertex_x,
    input  wire logic signed [18:0] i_vertex_y,
    input  wire logic signed [18:0] i_vertex_z,
    input  wire logic signed [18:0] i_sensor_x,
    input  wire logic signed [18:0] i_sensor_y,
    input  wire logic signed [18:0] i_sensor_z,

    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic        [18:0]      o_length_inside,
    output logic signed [20:0]      o_length_outside,

    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [0:0]         i_cfg_index,
    input  wire logic [18:0]        i_cfg_data
);

    // ---------------------------------------------------------------- config
    logic signed [18:0] r_center_z;
    logic        [17:0] r_radius;
    logic        [35:0] r_r2;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_z <= CZ_RESET;
            r_radius   <= RADIUS_RESET;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_CENTER_Z: r_center_z <= i_cfg_data;
                CFG_RADIUS:   r_radius   <= i_cfg_data[17:0];
                default: ;
            endcase
        end
    end

    // R^2 follows the radius in the next cycle; fine if config only changes when idle, a rule the user must keep
    always_ff @(posedge i_clk) begin
        r_r2 <= r_radius * r_radius;
    end

    // ---------------------------------------------------------------- flow
    logic w_en;
    logic r_vld [PIPE_DEPTH];

    assign w_en        = !r_vld[PIPE_DEPTH-1] || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_vld[PIPE_DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PIPE_DEPTH; k++) r_vld[k] <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= i_in_valid;
            for (int k = 1; k < PIPE_DEPTH; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // ---------------------------------------------------------------- stage 1
    // D = P - V, W = V - centre
    logic signed [18:0] r_s1_vx, r_s1_vy;
    logic signed [19:0] r_s1_dx, r_s1_dy, r_s1_dz, r_s1_wz;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_vx <= i_vertex_x;
            r_s1_vy <= i_vertex_y;
            r_s1_dx <= 20'(i_sensor_x) - 20'(i_vertex_x);
            r_s1_dy <= 20'(i_sensor_y) - 20'(i_vertex_y);
            r_s1_dz <= 20'(i_sensor_z) - 20'(i_vertex_z);
            r_s1_wz <= 20'(i_vertex_z) - 20'(r_center_z);
        end
    end

    // ---------------------------------------------------------------- stage 2
    // nine products; all squares are below 2^38
    logic signed [39:0] n_dxx, n_dyy, n_dzz, n_vxx, n_vyy, n_wzz;
    logic [37:0]        r_s2_dxx, r_s2_dyy, r_s2_dzz, r_s2_vxx, r_s2_vyy, r_s2_wzz;
    logic signed [39:0] r_s2_pvx, r_s2_pvy, r_s2_pwz;
    logic               r_s2_zero;

    always_comb begin
        n_dxx = r_s1_dx * r_s1_dx;
        n_dyy = r_s1_dy * r_s1_dy;
        n_dzz = r_s1_dz * r_s1_dz;
        n_vxx = r_s1_vx * r_s1_vx;
        n_vyy = r_s1_vy * r_s1_vy;
        n_wzz = r_s1_wz * r_s1_wz;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_dxx  <= n_dxx[37:0];
            r_s2_dyy  <= n_dyy[37:0];
            r_s2_dzz  <= n_dzz[37:0];
            r_s2_vxx  <= n_vxx[37:0];
            r_s2_vyy  <= n_vyy[37:0];
            r_s2_wzz  <= n_wzz[37:0];
            r_s2_pvx  <= r_s1_vx * r_s1_dx;
            r_s2_pvy  <= r_s1_vy * r_s1_dy;
            r_s2_pwz  <= r_s1_wz * r_s1_dz;
            r_s2_zero <= (r_s1_dx == '0) && (r_s1_dy == '0) && (r_s1_dz == '0);
        end
    end

    // ---------------------------------------------------------------- stage 3
    logic [39:0]        r_s3_dr2, r_s3_w2;
    logic signed [40:0] r_s3_dot;
    logic               r_s3_zero;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_dr2  <= 40'(r_s2_dxx) + 40'(r_s2_dyy) + 40'(r_s2_dzz);
            r_s3_w2   <= 40'(r_s2_vxx) + 40'(r_s2_vyy) + 40'(r_s2_wzz);
            r_s3_dot  <= 41'(r_s2_pvx) + 41'(r_s2_pvy) + 41'(r_s2_pwz);
            r_s3_zero <= r_s2_zero;
        end
    end

    // ---------------------------------------------------------------- |D| in Q8
    logic [SQ_OUT_W-1:0] w_root1;
    t_sq1_side           n_sq1_in;
    t_sq1_side           r_sq1_side [SQ_STAGES];
    logic signed [40:0]  n_dot_abs;

    lscps_sqrt u_sqrt_len (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_radicand ({4'b0, r_s3_dr2, 16'b0}),
        .o_root     (w_root1)
    );

    always_comb begin
        n_dot_abs        = r_s3_dot[40] ? -r_s3_dot : r_s3_dot;
        n_sq1_in.dot_neg = r_s3_dot[40];
        n_sq1_in.dot_mag = n_dot_abs[39:0];
        n_sq1_in.w2      = r_s3_w2;
        n_sq1_in.zero    = r_s3_zero;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq1_side[0] <= n_sq1_in;
            for (int k = 1; k < SQ_STAGES; k++) r_sq1_side[k] <= r_sq1_side[k-1];
        end
    end

    // ---------------------------------------------------------------- numerator
    // |W.D| * 2^16 + drq/2, rounding the quotient to nearest
    logic [DIV_NUM_W-1:0] r_sn_num;
    t_div_side            r_sn_side;
    t_div_side            r_div_side [DIV_STAGES];
    logic [DIV_Q_W-1:0]   w_um;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sn_num          <= {1'b0, r_sq1_side[SQ_STAGES-1].dot_mag, 16'b0}
                                 + DIV_NUM_W'(w_root1[28:1]);
            r_sn_side.dot_neg <= r_sq1_side[SQ_STAGES-1].dot_neg;
            r_sn_side.w2      <= r_sq1_side[SQ_STAGES-1].w2;
            r_sn_side.drq     <= w_root1[28:0];
            r_sn_side.zero    <= r_sq1_side[SQ_STAGES-1].zero;
        end
    end

    lscps_div u_div_proj (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_sn_num),
        .i_den (r_sn_side.drq),
        .o_quo (w_um)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_div_side[0] <= r_sn_side;
            for (int k = 1; k < DIV_STAGES; k++) r_div_side[k] <= r_div_side[k-1];
        end
    end

    // ---------------------------------------------------------------- u, u^2
    logic [57:0]        n_um2;
    logic [57:0]        r_su_um2;
    logic signed [29:0] r_su_u;
    logic [39:0]        r_su_w2;
    logic [28:0]        r_su_drq;
    logic               r_su_inside, r_su_zero;

    assign n_um2 = w_um * w_um;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_su_um2    <= n_um2;
            r_su_u      <= r_div_side[DIV_STAGES-1].dot_neg ? -30'(w_um) : 30'(w_um);
            r_su_w2     <= r_div_side[DIV_STAGES-1].w2;
            r_su_drq    <= r_div_side[DIV_STAGES-1].drq;
            r_su_inside <= r_div_side[DIV_STAGES-1].w2 < 40'(r_r2);
            r_su_zero   <= r_div_side[DIV_STAGES-1].zero;
        end
    end

    // ---------------------------------------------------------------- discriminant
    // s = u^2 - |W|^2 * 2^16 + R^2 * 2^16, Q16
    logic signed [60:0]  n_s;
    logic                n_spos;
    logic [SQ_IN_W-1:0]  r_ss_rad;
    t_sq2_side           r_ss_side;

    always_comb begin
        n_s    = $signed({3'b0, r_su_um2}) - $signed({5'b0, r_su_w2, 16'b0})
                 + $signed({9'b0, r_r2, 16'b0});
        n_spos = !n_s[60] && (n_s != '0);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ss_rad         <= n_spos ? n_s[SQ_IN_W-1:0] : '0;
            r_ss_side.u      <= r_su_u;
            r_ss_side.drq    <= r_su_drq;
            r_ss_side.vtx_in <= r_su_inside;
            r_ss_side.spos   <= n_spos;
            r_ss_side.zero   <= r_su_zero;
        end
    end

    // ---------------------------------------------------------------- q = sqrt(s)
    logic [SQ_OUT_W-1:0] w_q;
    t_sq2_side           r_sq2_side [SQ_STAGES];

    lscps_sqrt u_sqrt_disc (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_radicand (r_ss_rad),
        .o_root     (w_q)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq2_side[0] <= r_ss_side;
            for (int k = 1; k < SQ_STAGES; k++) r_sq2_side[k] <= r_sq2_side[k-1];
        end
    end

    // ---------------------------------------------------------------- roots
    logic signed [31:0] r_p1_a1, r_p1_a2;
    logic [28:0]        r_p1_drq;
    logic               r_p1_inside, r_p1_spos, r_p1_zero;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_a1     <= $signed({2'b0, w_q}) - 32'(r_sq2_side[SQ_STAGES-1].u);
            r_p1_a2     <= -32'(r_sq2_side[SQ_STAGES-1].u) - $signed({2'b0, w_q});
            r_p1_drq    <= r_sq2_side[SQ_STAGES-1].drq;
            r_p1_inside <= r_sq2_side[SQ_STAGES-1].vtx_in;
            r_p1_spos   <= r_sq2_side[SQ_STAGES-1].spos;
            r_p1_zero   <= r_sq2_side[SQ_STAGES-1].zero;
        end
    end

    // ---------------------------------------------------------------- path
    // vertex inside: far root if it lies ahead; outside: chord if both ahead
    logic signed [31:0] n_path;
    logic signed [31:0] r_p2_path;
    logic signed [32:0] r_p2_diff;
    logic               r_p2_zero;

    always_comb begin
        n_path = '0;
        if (r_p1_spos) begin
            if (r_p1_inside) begin
                if (r_p1_a1 > 0 && r_p1_a2 < 0) n_path = r_p1_a1;
            end else if (r_p1_a1 > 0 && r_p1_a2 > 0) begin
                n_path = r_p1_a1 - r_p1_a2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p2_path <= n_path;
            r_p2_diff <= $signed({4'b0, r_p1_drq}) - 33'(n_path);
            r_p2_zero <= r_p1_zero;
        end
    end

    // ---------------------------------------------------------------- output
    // Q8 to 1/16 mm, half away from zero, then saturate
    logic [32:0]        n_lin_sum;
    logic [24:0]        n_lin;
    logic [32:0]        n_out_mag;
    logic [33:0]        n_out_sum;
    logic [25:0]        n_out_m;
    logic        [18:0] n_len_in;
    logic signed [20:0] n_len_out;
    logic        [18:0] r_out_lin;
    logic signed [20:0] r_out_lout;

    always_comb begin
        n_lin_sum = {1'b0, r_p2_path} + 33'(1 << (QF - 1));
        n_lin     = n_lin_sum[32:QF];
        n_len_in  = (n_lin > 25'd524287) ? 19'd524287 : n_lin[18:0];

        n_out_mag = r_p2_diff[32] ? 33'(-r_p2_diff) : 33'(r_p2_diff);
        n_out_sum = {1'b0, n_out_mag} + 34'(1 << (QF - 1));
        n_out_m   = n_out_sum[33:QF];
        if (r_p2_diff[32]) begin
            n_len_out = (n_out_m > 26'd1048576) ? -21'sd1048576 : -$signed(21'(n_out_m));
        end else begin
            n_len_out = (n_out_m > 26'd1048575) ? 21'sd1048575 : $signed(21'(n_out_m));
        end

        // zero-length segment
        if (r_p2_zero) begin
            n_len_in  = '0;
            n_len_out = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_lin  <= n_len_in;
            r_out_lout <= n_len_out;
        end
    end

    assign o_length_inside  = r_out_lin;
    assign o_length_outside = r_out_lout;

endmodule

`default_nettype wire
